>>> rtl/core/assert_macros.svh
// Concurrent assertion macros used by the sort engine datapath.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define QS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QS_ASSERT(lbl, clk, rst_n, prop)
`define QS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/qs_pkg.sv
// Shared types, constants and the double compare for the sort engine.
// No dependencies.
package qs_pkg;

  localparam int unsigned DepthDef      = 64;
  localparam int unsigned StackDepthDef = 64;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_POP_RD, OP_POP, OP_PINIT, OP_PIVOT,
    OP_CHK_I, OP_CHK_J, OP_SWAP2, OP_NEXT, OP_PEND, OP_ORD, OP_OWR
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic cond_i;
    logic cond_j;
    logic i_le_j;
    logic left_more;
    logic sp_next_zero;
    logic out_free;
    logic last_k;
  } status_t;

  // C '<' on doubles; any compare with NaN is false; +0 and -0 compare equal
  function automatic logic lt_f(input logic [63:0] a, input logic [63:0] b);
    logic both_zero;
    logic a_nan;
    logic b_nan;
    logic res;
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    if (a_nan || b_nan) begin
      res = 1'b0;
    end else if (both_zero) begin
      res = 1'b0;
    end else if (a[63] != b[63]) begin
      res = a[63];
    end else if (!a[63]) begin
      res = a[62:0] < b[62:0];
    end else begin
      res = a[62:0] > b[62:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/qs_ctrl.sv
// Sequencer for load, partition, pop/push and unload phases.
// Depends on qs_pkg.
module qs_ctrl import qs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POPRD = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_PINIT = 4'd4;
  localparam logic [3:0] S_PIVOT = 4'd5;
  localparam logic [3:0] S_CHKI  = 4'd6;
  localparam logic [3:0] S_CHKJ  = 4'd7;
  localparam logic [3:0] S_SWAP2 = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_PEND  = 4'd10;
  localparam logic [3:0] S_ORD   = 4'd11;
  localparam logic [3:0] S_OWR   = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        if (status_i.load_done) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d = S_POPRD;
      end
      S_POPRD: begin
        cmd_o.op = OP_POP_RD;
        state_d = S_POP;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d = S_PINIT;
      end
      S_PINIT: begin
        cmd_o.op = OP_PINIT;
        state_d = S_PIVOT;
      end
      S_PIVOT: begin
        cmd_o.op = OP_PIVOT;
        state_d = S_CHKI;
      end
      S_CHKI: begin
        cmd_o.op = OP_CHK_I;
        if (!status_i.cond_i) state_d = S_CHKJ;
      end
      S_CHKJ: begin
        cmd_o.op = OP_CHK_J;
        if (!status_i.cond_j) state_d = status_i.i_le_j ? S_SWAP2 : S_PEND;
      end
      S_SWAP2: begin
        cmd_o.op = OP_SWAP2;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT;
        state_d = status_i.i_le_j ? S_CHKI : S_PEND;
      end
      S_PEND: begin
        cmd_o.op = OP_PEND;
        priority if (status_i.left_more) state_d = S_PINIT;
        else if (status_i.sp_next_zero) state_d = S_ORD;
        else state_d = S_POPRD;
      end
      S_ORD: begin
        cmd_o.op = OP_ORD;
        state_d = S_OWR;
      end
      S_OWR: begin
        cmd_o.op = OP_OWR;
        if (status_i.out_free) state_d = status_i.last_k ? S_LOAD : S_ORD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/qs_dp.sv
// Datapath: element store, range stack, scan indexes and output register.
// Depends on qs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qs_dp import qs_pkg::*; #(
  parameter int unsigned DEPTH       = DepthDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] sorted_value_o,
  output logic        end_of_run_o
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned SW  = IW + 2;
  localparam int unsigned SPW = $clog2(STACK_DEPTH);

  logic [63:0] store_mem [DEPTH];
  logic [63:0] srd_q;
  logic        s_we, s_re;
  logic [IW-1:0] s_waddr, s_raddr;
  logic [63:0] s_wdata;

  logic [2*IW-1:0] stack_mem [STACK_DEPTH];
  logic [2*IW-1:0] krd_q;
  logic            k_we, k_re;
  logic [SPW-1:0]  k_waddr, k_raddr;
  logic [2*IW-1:0] k_wdata;

  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, k_q, k_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic signed [SW-1:0] lb_q, lb_d, ub_q, ub_d, i_q, i_d, j_q, j_d, mid_q, mid_d;
  logic [63:0] pivot_q, pivot_d, vi_q, vi_d;
  logic        out_valid_q, out_valid_d, last_q, last_d;
  logic [63:0] out_q, out_d;

  logic accept, out_free, push_ok, go_left, push_en;
  logic signed [SW-1:0] i_inc, j_dec, nlb, nub, sum;
  logic [IW-1:0] push_lo, push_hi;

  assign in_ready_o = (cmd_i.op == OP_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign i_inc      = i_q + SW'(1);
  assign j_dec      = j_q - SW'(1);
  assign sum        = lb_q + ub_q;
  assign push_ok    = (sp_q != SPW'(STACK_DEPTH - 1));
  assign go_left    = (i_q < mid_q);

  always_comb begin
    push_en = 1'b0;
    push_lo = lb_q[IW-1:0];
    push_hi = j_q[IW-1:0];
    nlb = lb_q;
    nub = ub_q;
    if (go_left) begin
      push_en = (i_q < ub_q) && push_ok;
      push_lo = i_q[IW-1:0];
      push_hi = ub_q[IW-1:0];
      nub = j_q;
    end else begin
      push_en = (j_q > lb_q) && push_ok;
      nlb = i_q;
    end
  end

  always_comb begin
    status_o.load_done    = accept && (is_last_i || (cnt_q + CW'(1) == CW'(DEPTH)));
    status_o.cond_i       = (i_q < ub_q) && lt_f(srd_q, pivot_q);
    status_o.cond_j       = (j_q > lb_q) && lt_f(pivot_q, srd_q);
    status_o.i_le_j       = (i_q <= j_q);
    status_o.left_more    = (nlb < nub);
    status_o.sp_next_zero = (sp_q == '0) && !push_en;
    status_o.out_free     = out_free;
    status_o.last_k       = (k_q == n_q - CW'(1));
  end

  always_comb begin
    cnt_d = cnt_q; n_d = n_q; k_d = k_q; sp_d = sp_q;
    lb_d = lb_q; ub_d = ub_q; i_d = i_q; j_d = j_q; mid_d = mid_q;
    pivot_d = pivot_q; vi_d = vi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q; last_d = last_q;
    s_we = 1'b0; s_re = 1'b0; s_waddr = '0; s_raddr = '0; s_wdata = srd_q;
    k_we = 1'b0; k_re = 1'b0; k_waddr = '0; k_raddr = sp_q; k_wdata = '0;
    unique case (cmd_i.op)
      OP_LOAD: begin
        if (accept) begin
          s_we = 1'b1;
          s_waddr = cnt_q[IW-1:0];
          s_wdata = value_i;
          cnt_d = cnt_q + CW'(1);
          n_d = cnt_q + CW'(1);
        end
      end
      OP_INIT: begin
        k_we = 1'b1;
        k_waddr = SPW'(1);
        k_wdata = {IW'(0), IW'(n_q - CW'(1))};
        sp_d = SPW'(1);
        cnt_d = '0;
        k_d = '0;
      end
      OP_POP_RD: k_re = 1'b1;
      OP_POP: begin
        lb_d = SW'(krd_q[2*IW-1:IW]);
        ub_d = SW'(krd_q[IW-1:0]);
        sp_d = sp_q - SPW'(1);
      end
      OP_PINIT: begin
        mid_d = sum >>> 1;
        i_d = lb_q;
        j_d = ub_q;
        s_re = 1'b1;
        s_raddr = mid_d[IW-1:0];
      end
      OP_PIVOT: begin
        pivot_d = srd_q;
        s_re = 1'b1;
        s_raddr = i_q[IW-1:0];
      end
      OP_CHK_I: begin
        s_re = 1'b1;
        if (status_o.cond_i) begin
          i_d = i_inc;
          s_raddr = i_inc[IW-1:0];
        end else begin
          vi_d = srd_q;
          s_raddr = j_q[IW-1:0];
        end
      end
      OP_CHK_J: begin
        if (status_o.cond_j) begin
          j_d = j_dec;
          s_re = 1'b1;
          s_raddr = j_dec[IW-1:0];
        end else if (status_o.i_le_j) begin
          s_we = 1'b1;
          s_waddr = i_q[IW-1:0];
          s_wdata = srd_q;
        end
      end
      OP_SWAP2: begin
        s_we = 1'b1;
        s_waddr = j_q[IW-1:0];
        s_wdata = vi_q;
        i_d = i_inc;
        j_d = j_dec;
      end
      OP_NEXT: begin
        s_re = status_o.i_le_j;
        s_raddr = i_q[IW-1:0];
      end
      OP_PEND: begin
        lb_d = nlb;
        ub_d = nub;
        if (push_en) begin
          k_we = 1'b1;
          k_waddr = sp_q + SPW'(1);
          k_wdata = {push_lo, push_hi};
          sp_d = sp_q + SPW'(1);
        end
      end
      OP_ORD: begin
        s_re = 1'b1;
        s_raddr = k_q[IW-1:0];
      end
      OP_OWR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = srd_q;
          last_d = status_o.last_k;
          k_d = k_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) store_mem[s_waddr] <= s_wdata;
    if (s_re) srd_q <= store_mem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (k_we) stack_mem[k_waddr] <= k_wdata;
    if (k_re) krd_q <= stack_mem[k_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q <= '0;
      k_q <= '0;
      sp_q <= '0;
      lb_q <= '0;
      ub_q <= '0;
      i_q <= '0;
      j_q <= '0;
      mid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      n_q <= n_d;
      k_q <= k_d;
      sp_q <= sp_d;
      lb_q <= lb_d;
      ub_q <= ub_d;
      i_q <= i_d;
      j_q <= j_d;
      mid_q <= mid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pivot_q <= pivot_d;
    vi_q <= vi_d;
    out_q <= out_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_q;
  assign end_of_run_o   = last_q;

  // count reaches DEPTH for the one cycle between the last load and INIT
  `QS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `QS_ASSERT(a_j_floor, clk_i, rst_ni, j_q >= -SW'(1))
  `QS_ASSERT_NEXT(a_init_sp, clk_i, rst_ni, cmd_i.op == OP_INIT, sp_q == SPW'(1))

endmodule

>>> rtl/core/iterative_quicksort_engine.sv
// Operation: the set is loaded, then sorted with scan compares, exchanges, a pivot
// read per partition, a closing step per partition and pops from the range stack;
// then the sorted values are sent out one by one.
// Throughput: one set at a time; one store access per cycle sets the pace.
// Loading takes one transaction per cycle while in_valid_i is high; the next set
// loads while the final result still waits in the output register.
// Reset: rst_ni asynchronous, active low; clears counters and the sequencer.
module iterative_quicksort_engine import qs_pkg::*; #(
  parameter int unsigned DEPTH       = DepthDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] sorted_value_o,
  output logic        end_of_run_o
);

  // Command and status between the sequencer and the datapath
  cmd_t    cmd;
  status_t status;

  qs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Element store and range stack live in the datapath; each partition
  // scans with one store read per cycle.
  qs_dp #(
    .DEPTH       (DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule
